// File: rtl/pl_engine_pkg.sv
package pl_engine_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 6;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_GET    = 3'd2;
    localparam logic [2:0] ACT_LOCATE = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_COUNT = 3'd1;
    localparam logic [2:0] IDX_POS   = 3'd2;
    localparam logic [2:0] IDX_ZERO  = 3'd3;
    localparam logic [2:0] IDX_INC   = 3'd4;
    localparam logic [2:0] IDX_DEC   = 3'd5;

    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_IDX   = 2'd1;
    localparam logic [1:0] RD_IDXM1 = 2'd2;
    localparam logic [1:0] RD_POSM1 = 2'd3;

    localparam logic [1:0] WR_NONE     = 2'd0;
    localparam logic [1:0] WR_SHIFT_UP = 2'd1;
    localparam logic [1:0] WR_SHIFT_DN = 2'd2;
    localparam logic [1:0] WR_PUT      = 2'd3;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_ZERO = 2'd3;

    typedef struct packed {
        logic [2:0]        action;
        logic [POS_W-1:0]  position;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [5:0]         list_length;
        logic               is_empty;
    } t_out;

    typedef struct packed {
        logic       req_load;
        logic [2:0] idx_op;
        logic [1:0] rd_op;
        logic [1:0] wr_op;
        logic [1:0] cnt_op;
        logic       save_rd;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_with_rd;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       full;
        logic       pos_ins_ok;
        logic       pos_rd_ok;
        logic       pos_at_end;
        logic       pos_at_cnt;
        logic       cnt_zero;
        logic       idx_eq_pos;
        logic       idx_last;
        logic       match;
        logic       out_free;
    } t_stat;

endpackage

// File: rtl/pl_engine_ctrl.sv
module pl_engine_ctrl
    import pl_engine_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_INS_PUT = 4'd4;
    localparam logic [3:0] S_RD_DATA = 4'd5;
    localparam logic [3:0] S_DEL_RD  = 4'd6;
    localparam logic [3:0] S_DEL_WR  = 4'd7;
    localparam logic [3:0] S_LOC_RD  = 4'd8;
    localparam logic [3:0] S_LOC_CMP = 4'd9;
    localparam logic [3:0] S_FINISH  = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_st, n_st;
    logic       r_use_rd, n_use_rd;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_st     = r_st;
        n_use_rd = r_use_rd;
        o_cmd    = '0;
        o_cmd.res_status  = r_st;
        o_cmd.res_with_rd = r_use_rd;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_use_rd = 1'b0;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FINISH;
                case (i_stat.action)
                    ACT_INSERT: begin
                        if (i_stat.full) begin
                            n_st = ST_FULL;
                        end else if (!i_stat.pos_ins_ok) begin
                            n_st = ST_BADPOS;
                        end else begin
                            o_cmd.idx_op = IDX_COUNT;
                            n_state = i_stat.pos_at_end ? S_INS_PUT : S_INS_RD;
                        end
                    end
                    ACT_DELETE, ACT_GET: begin
                        if (!i_stat.pos_rd_ok) begin
                            n_st = ST_BADPOS;
                        end else begin
                            o_cmd.rd_op  = RD_POSM1;
                            o_cmd.idx_op = IDX_POS;
                            n_state = S_RD_DATA;
                        end
                    end
                    ACT_LOCATE: begin
                        if (i_stat.cnt_zero) begin
                            n_st = ST_NOTFOUND;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state = S_LOC_RD;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.cnt_op = CNT_ZERO;
                        n_st = ST_OK;
                    end
                    default: begin
                        n_st = ST_BADPOS;
                    end
                endcase
            end
            S_INS_RD: begin
                o_cmd.rd_op = RD_IDXM1;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.wr_op  = WR_SHIFT_UP;
                o_cmd.idx_op = IDX_DEC;
                n_state = i_stat.idx_eq_pos ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT: begin
                o_cmd.wr_op  = WR_PUT;
                o_cmd.cnt_op = CNT_INC;
                n_st    = ST_OK;
                n_state = S_FINISH;
            end
            S_RD_DATA: begin
                o_cmd.save_rd = 1'b1;
                n_st     = ST_OK;
                n_use_rd = 1'b1;
                if (i_stat.action == ACT_GET) begin
                    n_state = S_FINISH;
                end else if (i_stat.pos_at_cnt) begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DEL_RD;
                end
            end
            S_DEL_RD: begin
                o_cmd.rd_op = RD_IDX;
                n_state = S_DEL_WR;
            end
            S_DEL_WR: begin
                o_cmd.wr_op  = WR_SHIFT_DN;
                o_cmd.idx_op = IDX_INC;
                if (i_stat.idx_last) begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DEL_RD;
                end
            end
            S_LOC_RD: begin
                o_cmd.rd_op = RD_IDX;
                n_state = S_LOC_CMP;
            end
            S_LOC_CMP: begin
                if (i_stat.match) begin
                    n_st    = ST_OK;
                    n_state = S_FINISH;
                end else if (i_stat.idx_last) begin
                    n_st    = ST_NOTFOUND;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state = S_LOC_RD;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_st     <= ST_OK;
            r_use_rd <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_st     <= n_st;
            r_use_rd <= n_use_rd;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE))
        else $error("accepted item did not reach decode");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> i_stat.out_free)
        else $error("result loaded over a waiting result");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (o_cmd.wr_op == WR_NONE && o_cmd.cnt_op == CNT_HOLD))
        else $error("list modified while idle");

    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !i_stat.out_free) |=> (r_state == S_FINISH))
        else $error("result dropped while output busy");
`endif

endmodule

// File: rtl/pl_engine_dp.sv
module pl_engine_dp
    import pl_engine_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_item,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_out  o_out_item
);

    logic [31:0]       mem [CAPACITY];
    t_in               r_req;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_idx;
    logic [31:0]       r_rdata;
    logic [31:0]       r_rd;
    t_out              r_out;
    logic              r_out_valid;

    logic [CMP_W-1:0]  count_x, pos_x, idx_x, pos_m1;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [31:0]       wr_data;

    assign count_x = CMP_W'(r_count);
    assign pos_x   = CMP_W'(r_req.position);
    assign idx_x   = CMP_W'(r_idx);
    assign pos_m1  = pos_x - CMP_W'(1);

    assign o_stat.action     = r_req.action;
    assign o_stat.full       = (count_x >= CMP_W'(CAPACITY));
    assign o_stat.pos_ins_ok = (pos_x != '0) && (pos_x <= count_x + CMP_W'(1));
    assign o_stat.pos_rd_ok  = (pos_x != '0) && (pos_x <= count_x);
    assign o_stat.pos_at_end = (pos_x == count_x + CMP_W'(1));
    assign o_stat.pos_at_cnt = (pos_x == count_x);
    assign o_stat.cnt_zero   = (r_count == '0);
    assign o_stat.idx_eq_pos = (idx_x == pos_x);
    assign o_stat.idx_last   = (idx_x + CMP_W'(1) >= count_x);
    assign o_stat.match      = (r_rdata == r_req.value);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_idx;
        case (i_cmd.rd_op)
            RD_IDX:   rd_addr = r_idx;
            RD_IDXM1: rd_addr = r_idx - ADDR_W'(1);
            RD_POSM1: rd_addr = pos_m1[ADDR_W-1:0];
            default:  rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx;
        wr_data = r_rdata;
        case (i_cmd.wr_op)
            WR_SHIFT_UP: wr_addr = r_idx;
            WR_SHIFT_DN: wr_addr = r_idx - ADDR_W'(1);
            WR_PUT: begin
                wr_addr = pos_m1[ADDR_W-1:0];
                wr_data = r_req.value;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC:  n_count = r_count + CNT_W'(1);
            CNT_DEC:  n_count = r_count - CNT_W'(1);
            CNT_ZERO: n_count = '0;
            default:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_item;
        end
        if (i_cmd.save_rd) begin
            r_rd <= r_rdata;
        end
        case (i_cmd.idx_op)
            IDX_COUNT: r_idx <= count_x[ADDR_W-1:0];
            IDX_POS:   r_idx <= pos_x[ADDR_W-1:0];
            IDX_ZERO:  r_idx <= '0;
            IDX_INC:   r_idx <= r_idx + ADDR_W'(1);
            IDX_DEC:   r_idx <= r_idx - ADDR_W'(1);
            default:   r_idx <= r_idx;
        endcase
        if (i_cmd.res_load) begin
            r_out.status      <= i_cmd.res_status;
            r_out.read_value  <= i_cmd.res_with_rd ? r_rd : 32'd0;
            r_out.list_length <= count_x[5:0];
            r_out.is_empty    <= (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_x <= CMP_W'(CAPACITY))
        else $error("count beyond capacity");

    a_put_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_op == WR_PUT) |-> (!o_stat.full && o_stat.pos_ins_ok))
        else $error("insert into full list or bad position");

    a_dec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == CNT_DEC) |-> !o_stat.cnt_zero)
        else $error("delete from empty list");
`endif

endmodule

// File: rtl/positional_list_engine_unit.sv
// Positional list engine: ordered list of signed 32-bit words, 1-based positions.
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one request:
// insert, delete, get, locate or clear. Output channel (o_out_valid /
// i_out_ready / o_out_item) returns one result per request: status, read
// value, new length and empty flag.
// Entries sit in a one-port-write, one-port-read memory with registered
// read data; a sequencer moves one entry at a time, a read and then a write.
// Steps after accept: clear, full, bad position, bad action and locate on an
// empty list settle at decode; get reads the entry at the position; insert
// shifts up each entry from the position to the end, then puts the value;
// delete reads the entry, then shifts down each entry after it; locate
// reads and compares entries until the first match or the last entry.
// One request is in flight at a time; the next is accepted the cycle after
// its result is loaded into the output register.
// Reset (synchronous, active low) empties the list and drops any result.
// A stalled receiver holds the result in the output register; a finished
// request waits until that register frees.
module positional_list_engine_unit
    import pl_engine_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    t_cmd  cmd;
    t_stat stat;

    pl_engine_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pl_engine_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pl_engine_pkg::*;

    localparam int NUM_RANDOM      = 900;
    localparam int SEGMENT_ITEMS   = 50;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 400;
    localparam int TAIL_CYCLES     = 100;
    localparam int WATCHDOG_CYCLES = 1500;

    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    class list_scoreboard;
        logic signed [31:0] words [CAPACITY];
        int unsigned        len;
        t_out               expected_q [$];
        int                 errors;
        int                 accepted;

        function new();
            len      = 0;
            errors   = 0;
            accepted = 0;
        endfunction

        function void note_request(t_in req);
            t_out        res;
            int unsigned pos;
            int unsigned k;
            pos            = 32'(req.position);
            res.status     = ST_BADPOS;
            res.read_value = '0;
            case (req.action)
                ACT_INSERT: begin
                    if (len >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else if (pos >= 1 && pos <= len + 1) begin
                        for (k = len; k > pos - 1; k--) begin
                            words[k] = words[k - 1];
                        end
                        words[pos - 1] = req.value;
                        len++;
                        res.status = ST_OK;
                    end
                end
                ACT_DELETE: begin
                    if (pos >= 1 && pos <= len) begin
                        res.read_value = words[pos - 1];
                        for (k = pos; k < len; k++) begin
                            words[k - 1] = words[k];
                        end
                        len--;
                        res.status = ST_OK;
                    end
                end
                ACT_GET: begin
                    if (pos >= 1 && pos <= len) begin
                        res.read_value = words[pos - 1];
                        res.status     = ST_OK;
                    end
                end
                ACT_LOCATE: begin
                    res.status = ST_NOTFOUND;
                    for (k = 0; k < len; k++) begin
                        if (words[k] == req.value) begin
                            res.status = ST_OK;
                            break;
                        end
                    end
                end
                ACT_CLEAR: begin
                    len        = 0;
                    res.status = ST_OK;
                end
                default: begin
                    res.status = ST_BADPOS;
                end
            endcase
            res.list_length = 6'(len);
            res.is_empty    = (len == 0);
            expected_q.push_back(res);
            accepted++;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: status %0d value %0d length %0d",
                       got.status, got.read_value, got.list_length);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                errors++;
            end
            if (got.list_length !== want.list_length) begin
                $error("list_length: expected %0d, got %0d",
                       want.list_length, got.list_length);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                errors++;
            end
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_item   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_item;

    list_scoreboard sb = new();
    int             idle_cycles = 0;

    positional_list_engine_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_in req(logic [2:0] act, logic [5:0] pos, logic signed [31:0] val);
        t_in it;
        it.action   = act;
        it.position = pos;
        it.value    = val;
        return it;
    endfunction

    function automatic logic [2:0] pick_unused();
        return 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    endfunction

    function automatic t_in make_item(t_mix mix);
        t_in         it;
        int          r;
        int unsigned len;
        len = sb.len;
        r   = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                it.action = (r < 70) ? ACT_INSERT : (r < 78) ? ACT_GET :
                            (r < 88) ? ACT_LOCATE : (r < 96) ? ACT_DELETE :
                            (r < 98) ? ACT_CLEAR  : pick_unused();
            end
            MIX_DRAIN: begin
                it.action = (r < 15) ? ACT_INSERT : (r < 65) ? ACT_DELETE :
                            (r < 78) ? ACT_GET    : (r < 92) ? ACT_LOCATE :
                            (r < 95) ? ACT_CLEAR  : pick_unused();
            end
            default: begin
                it.action = (r < 35) ? ACT_INSERT : (r < 60) ? ACT_DELETE :
                            (r < 76) ? ACT_GET    : (r < 93) ? ACT_LOCATE :
                            (r < 96) ? ACT_CLEAR  : pick_unused();
            end
        endcase
        if ($urandom_range(0, 99) < 15) begin
            it.position = 6'($urandom_range(0, 63));
        end else if (it.action == ACT_INSERT) begin
            it.position = 6'($urandom_range(1, len + 1));
        end else if (len > 0) begin
            it.position = 6'($urandom_range(1, len));
        end else begin
            it.position = 6'($urandom_range(0, 63));
        end
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 4))
                0:       it.value = WORD_MIN;
                1:       it.value = WORD_MAX;
                2:       it.value = -32'sd1;
                3:       it.value = 32'sd1;
                default: it.value = '0;
            endcase
        end else if (r < 45 && len > 0) begin
            it.value = sb.words[$urandom_range(0, len - 1)];
        end else begin
            it.value = $urandom;
        end
        return it;
    endfunction

    task automatic offer(t_in it, bit calm);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(it);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall;
        int window;
        bit calm;
        bit pressed;
        stall   = 0;
        window  = 0;
        calm    = 1'b0;
        pressed = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out_item);
            end
            if (window == 0) begin
                calm   = ($urandom_range(0, 3) == 0);
                window = 64;
            end
            window--;
            if (!pressed && sb.accepted >= PRESSURE_AT) begin
                pressed = 1'b1;
                stall   = PRESSURE_CYCLES;
            end else if (stall == 0 && !calm && $urandom_range(0, 99) < 20) begin
                stall = pick_gap(1'b0);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_mix mix;
        bit   calm;
        int   n;
        mix  = MIX_BALANCED;
        calm = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(req(ACT_CLEAR,  6'd0,  '0), calm);
        offer(req(ACT_GET,    6'd1,  '0), calm);
        offer(req(ACT_DELETE, 6'd1,  '0), calm);
        offer(req(ACT_LOCATE, 6'd0,  '0), calm);
        offer(req(ACT_INSERT, 6'd0,  32'sd5), calm);
        offer(req(ACT_INSERT, 6'd2,  32'sd6), calm);
        offer(req(ACT_INSERT, 6'd1,  WORD_MAX), calm);
        offer(req(ACT_INSERT, 6'd1,  WORD_MIN), calm);
        offer(req(ACT_INSERT, 6'd3,  '0), calm);
        offer(req(ACT_INSERT, 6'd2,  -32'sd1), calm);
        offer(req(ACT_GET,    6'd1,  '0), calm);
        offer(req(ACT_GET,    6'd4,  '0), calm);
        offer(req(ACT_GET,    6'd5,  '0), calm);
        offer(req(ACT_GET,    6'd63, '0), calm);
        offer(req(ACT_LOCATE, 6'd0,  WORD_MIN), calm);
        offer(req(ACT_LOCATE, 6'd63, 32'sd12345), calm);
        offer(req(ACT_DELETE, 6'd2,  '0), calm);
        offer(req(ACT_DELETE, 6'd3,  '0), calm);
        offer(req(ACT_DELETE, 6'd0,  '0), calm);
        offer(req(ACT_UNUSED_LO, 6'd1, '0), calm);
        offer(req(ACT_UNUSED_LO + 3'd1, 6'd2, 32'sh5555_5555), calm);
        offer(req(ACT_UNUSED_HI, 6'd63, -32'sd1), calm);
        offer(req(ACT_INSERT, 6'd63, 32'sh5555_5555), calm);
        offer(req(ACT_CLEAR,  6'd63, -32'sd1), calm);
        offer(req(ACT_GET,    6'd1,  '0), calm);

        for (n = 0; n < NUM_RANDOM; n++) begin
            if (n % SEGMENT_ITEMS == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: mix = MIX_FILL;
                    4, 5, 6:    mix = MIX_DRAIN;
                    default:    mix = MIX_BALANCED;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            offer(make_item(mix), calm);
        end
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
